FILE: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, payload types and state encoding of the text console.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [COL_W-1:0] COLS_C     = COL_W'(COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST_C = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROWS_C     = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST_C = ROW_W'(ROWS - 1);

  localparam logic [ADDR_W-1:0] CELL_LAST_C  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_BASE_C   = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] COLS_ADDR_C  = ADDR_W'(COLUMNS);

  localparam logic [1:0] FN_PUT   = 2'd0;
  localparam logic [1:0] FN_CLEAR = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = CFG_IDX_W'(1);

  localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_ERROR   = 8'h45;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       char_code;
    logic [7:0]       attr;
    logic             use_cursor;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             error;
    logic             scrolled;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
  } out_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] chr;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    logic [7:0] default_attr;
    logic [7:0] error_attr;
  } cfg_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCROLL,
    S_FILL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: src/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Operation sequencer: decodes a beat, updates the cursor, and drives the
// screen RAM for cell writes, reads, scroll copy and fill passes.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire tcw_pkg::in_t              in_data,
  input  wire tcw_pkg::cfg_t             cfg,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output tcw_pkg::out_t                  res_data,
  output logic                           ram_we,
  output logic [tcw_pkg::ADDR_W-1:0]     ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0]     ram_wdata,
  output logic                           ram_re,
  output logic [tcw_pkg::ADDR_W-1:0]     ram_raddr,
  input  wire logic [tcw_pkg::CELL_W-1:0] ram_rdata
);

  import tcw_pkg::*;

  state_t            state_r, state_nxt;
  in_t               req_r, req_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              err_r, err_nxt;
  logic              scr_r, scr_nxt;
  cell_t             cell_r, cell_nxt;

  logic [COL_W-1:0]  eff_col;
  logic [ROW_W-1:0]  eff_row;
  logic              bad;
  logic [ADDR_W-1:0] addr_eff;
  logic [7:0]        attr_eff;
  logic              newline;
  logic              line_end;
  logic [COL_W-1:0]  step_col;
  logic [ROW_W-1:0]  step_row;
  logic              wrap;
  logic [ROW_W-1:0]  put_row;
  cell_t             fill_cell;

  assign eff_col  = req_r.use_cursor ? cur_col_r : req_r.col;
  assign eff_row  = req_r.use_cursor ? cur_row_r : req_r.row;
  assign bad      = !req_r.use_cursor && (req_r.col >= COLS_C || req_r.row >= ROWS_C);
  assign addr_eff = ADDR_W'(eff_row) * COLS_ADDR_C + ADDR_W'(eff_col);
  assign attr_eff = (req_r.attr == 8'd0) ? cfg.default_attr : req_r.attr;
  assign newline  = req_r.char_code == CH_NEWLINE;
  assign line_end = eff_col == COL_LAST_C;
  assign step_col = (newline || line_end) ? '0 : eff_col + 1'b1;
  assign step_row = (newline || line_end) ? eff_row + 1'b1 : eff_row;
  assign wrap     = step_row == ROWS_C;
  assign put_row  = wrap ? ROW_LAST_C : step_row;
  assign fill_cell = (req_r.func == FN_CLEAR) ? cell_t'{attr: cfg.default_attr, chr: CH_SPACE}
                                              : cell_t'('0);

  assign res_data = '{cursor_col: cur_col_r, cursor_row: cur_row_r, error: err_r,
                      scrolled: scr_r, cell_char: cell_r.chr, cell_attr: cell_r.attr};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (cnt_r == CELL_LAST_C) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        priority if (req_r.func == FN_CLEAR) state_nxt = S_FILL;
        else if (req_r.func == FN_READ && !bad) state_nxt = S_RDWAIT;
        else if (req_r.func == FN_PUT && !bad && wrap) state_nxt = S_SCROLL;
        else state_nxt = S_DONE;
      end
      S_RDWAIT: begin
        state_nxt = S_DONE;
      end
      S_SCROLL: begin
        if (cnt_r == ROW_BASE_C) state_nxt = S_FILL;
      end
      S_FILL: begin
        if (cnt_r == CELL_LAST_C) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cnt_r;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = addr_eff;
    req_nxt     = req_r;
    cnt_nxt     = cnt_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    err_nxt     = err_r;
    scr_nxt     = scr_r;
    cell_nxt    = cell_r;
    unique case (state_r)
      S_INIT: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        req_nxt  = in_data;
      end
      S_EXEC: begin
        err_nxt  = 1'b0;
        scr_nxt  = 1'b0;
        cell_nxt = '0;
        cnt_nxt  = '0;
        unique case (req_r.func)
          FN_PUT: begin
            if (bad) begin
              ram_we    = 1'b1;
              ram_waddr = CELL_LAST_C;
              ram_wdata = cell_t'{attr: cfg.error_attr, chr: CH_ERROR};
              err_nxt   = 1'b1;
            end else begin
              ram_we      = !newline;
              ram_waddr   = addr_eff;
              ram_wdata   = cell_t'{attr: attr_eff, chr: req_r.char_code};
              cur_col_nxt = step_col;
              cur_row_nxt = put_row;
              scr_nxt     = wrap;
            end
          end
          FN_CLEAR: begin
            cur_col_nxt = '0;
            cur_row_nxt = '0;
          end
          FN_READ: begin
            err_nxt = bad;
            ram_re  = !bad;
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        cell_nxt = cell_t'(ram_rdata);
      end
      S_SCROLL: begin
        ram_re    = cnt_r != ROW_BASE_C;
        ram_raddr = cnt_r + COLS_ADDR_C;
        ram_we    = cnt_r != '0;
        ram_waddr = cnt_r - 1'b1;
        ram_wdata = ram_rdata;
        cnt_nxt   = (cnt_r == ROW_BASE_C) ? ROW_BASE_C : cnt_r + 1'b1;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fill_cell;
        cnt_nxt   = cnt_r + 1'b1;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      cnt_r     <= '0;
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    err_r  <= err_nxt;
    scr_r  <= scr_nxt;
    cell_r <= cell_nxt;
  end

endmodule

`default_nettype wire

FILE: src/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine: character/attribute screen RAM with a cursor.
//
//   channel | dir | beat payload                     | handshake
//   in_     | in  | in_t: func, char, attr, position | in_valid / in_ready
//   out_    | out | out_t: cursor, flags, cell read  | out_valid / out_ready
//   cfg_    | in  | register index, 8-bit data      | cfg_valid / cfg_ready
//
// A put that scrolls also copies the rows up and zeroes the bottom row; a
// clear rewrites every cell with spaces; both passes go through the single
// write port of the screen RAM.
// After reset the RAM is zeroed; in_ready stays low meanwhile.
// A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire tcw_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output tcw_pkg::out_t                       out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]                     cfg_data
);

  import tcw_pkg::*;

  cfg_t              cfg_r;
  logic              out_valid_r;
  out_t              out_data_r;
  logic              res_valid;
  logic              res_ready;
  out_t              res_data;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_attr <= DEFAULT_ATTR_RST;
      cfg_r.error_attr   <= ERROR_ATTR_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DEFAULT_ATTR) cfg_r.default_attr <= cfg_data;
      if (cfg_index == CFG_ERROR_ATTR)   cfg_r.error_attr   <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_ram #(
    .DATA_W (CELL_W),
    .DEPTH  (CELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("beat accepted while previous operation in flight");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cursor_col < COLS_C) && (out_data.cursor_row < ROWS_C))
    else $error("cursor out of screen");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scrolled |->
      (out_data.cursor_col == '0) && (out_data.cursor_row == ROW_LAST_C) && !out_data.error)
    else $error("scroll left cursor off the bottom row start");

endmodule

`default_nettype wire
